// ----- design/integer_to_ascii_radix_formatter_core_assert.svh -----
// Assertion macros used by the checker file of the formatter core.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_CORE_ASSERT_SVH

// Implication in the same cycle, off while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Implication into the next cycle, off while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// Invariant checked at every edge, reset included.
`define AST_ALWAYS(label, clk, cond) \
	label: assert property (@(posedge clk) (cond)) \
		else $error("invariant check failed");

`endif

// ----- design/itoa_fmt_pkg.sv -----
// ---------------------------------------------------------------------------
// itoa_fmt_pkg
// Types, mode codes and character constants of the ASCII radix formatter.
// ---------------------------------------------------------------------------
`default_nettype none

package itoa_fmt_pkg;

	// Input mode codes
	localparam logic [2:0] MODE_SDEC = 3'd0;
	localparam logic [2:0] MODE_OCT  = 3'd1;
	localparam logic [2:0] MODE_UDEC = 3'd2;
	localparam logic [2:0] MODE_HEX  = 3'd3;
	localparam logic [2:0] MODE_PTR  = 3'd4;

	// Fixed characters
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_A_M10 = 8'h57;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [63:0] value;
	} item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} result_t;

	// Classified conversion job handed from front to back
	typedef struct packed {
		base_t       base;
		logic        neg;
		logic        ptr;
		logic [63:0] mag;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Map a digit value to its lowercase ASCII glyph
	function automatic logic [7:0] glyph(input logic [3:0] d);
		if (d < 4'd10) begin
			return CHAR_ZERO + {4'b0, d};
		end
		return CHAR_A_M10 + {4'b0, d};
	endfunction

endpackage

`default_nettype wire

// ----- design/itoa_fmt_front.sv -----
// ---------------------------------------------------------------------------
// itoa_fmt_front
// Accepts commands, drops unused modes and builds a conversion job.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_fmt_front #(
	parameter int POINTER_WIDTH = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  itoa_fmt_pkg::item_t      item,
	input  itoa_fmt_pkg::fifo_stat_t stat,
	output itoa_fmt_pkg::push_t      push
);

	localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - POINTER_WIDTH);

	logic               valid_s1;
	itoa_fmt_pkg::job_t job_s1;
	itoa_fmt_pkg::job_t job_d;
	logic               mode_ok;
	logic               take;

	// Classify the incoming item
	always_comb begin
		job_d.base = itoa_fmt_pkg::BASE_DEC;
		job_d.neg  = 1'b0;
		job_d.ptr  = 1'b0;
		job_d.mag  = {32'b0, item.value[31:0]};
		mode_ok    = 1'b1;
		unique case (item.mode)
			itoa_fmt_pkg::MODE_SDEC: begin
				if (item.value[31]) begin
					job_d.neg = 1'b1;
					job_d.mag = {32'b0, ~item.value[31:0] + 32'd1};
				end
			end
			itoa_fmt_pkg::MODE_OCT:  job_d.base = itoa_fmt_pkg::BASE_OCT;
			itoa_fmt_pkg::MODE_UDEC: job_d.base = itoa_fmt_pkg::BASE_DEC;
			itoa_fmt_pkg::MODE_HEX:  job_d.base = itoa_fmt_pkg::BASE_HEX;
			itoa_fmt_pkg::MODE_PTR: begin
				job_d.base = itoa_fmt_pkg::BASE_HEX;
				job_d.ptr  = 1'b1;
				job_d.mag  = item.value & PTR_MASK;
			end
			default: mode_ok = 1'b0;
		endcase
	end

	assign busy = valid_s1 && stat.full;
	assign take = start && !busy;

	// Hold the job until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= mode_ok;
		end else if (valid_s1 && !stat.full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= job_d;
		end
	end

	assign push.valid = valid_s1;
	assign push.job   = job_s1;

endmodule

`default_nettype wire

// ----- design/itoa_fmt_fifo.sv -----
// ---------------------------------------------------------------------------
// itoa_fmt_fifo
// Two-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_fmt_fifo (
	input  wire                      clk,
	input  wire                      arst_n,
	input  itoa_fmt_pkg::push_t      push,
	input  wire                      pop,
	output itoa_fmt_pkg::job_t       head,
	output itoa_fmt_pkg::fifo_stat_t stat
);

	itoa_fmt_pkg::job_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign do_push    = push.valid && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

`default_nettype wire

// ----- design/itoa_fmt_back.sv -----
// ---------------------------------------------------------------------------
// itoa_fmt_back
// Converts one job to digits and emits its characters, one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module itoa_fmt_back #(
	parameter int POINTER_WIDTH = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  itoa_fmt_pkg::job_t       head,
	input  itoa_fmt_pkg::fifo_stat_t stat,
	output logic                     pop,
	output logic                     strobe,
	output itoa_fmt_pkg::result_t    result
);

	localparam int NIB = (POINTER_WIDTH + 3) / 4;
	localparam int PAD = 64 - 4 * NIB;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_SKIP,
		ST_PRE,
		ST_DIG
	} state_t;

	state_t      state_q;
	logic [63:0] digits_q;
	logic [39:0] bcd_q;
	logic [31:0] bin_q;
	logic [2:0]  step_q;
	logic [4:0]  cnt_q;
	logic        oct_q;
	logic        neg_q;
	logic        ptr_q;
	logic        pre_idx_q;
	logic [3:0]  top;
	logic [63:0] digits_shl;
	logic [39:0] bcd_next;

	// Shift four binary bits into the BCD accumulator
	function automatic logic [39:0] dabble4(input logic [39:0] bcd_in, input logic [3:0] bits);
		logic [39:0] acc;
		acc = bcd_in;
		for (int k = 3; k >= 0; k--) begin
			for (int n = 0; n < 10; n++) begin
				if (acc[4*n +: 4] >= 4'd5) begin
					acc[4*n +: 4] = acc[4*n +: 4] + 4'd3;
				end
			end
			acc = {acc[38:0], bits[k]};
		end
		return acc;
	endfunction

	assign top        = oct_q ? {1'b0, digits_q[63:61]} : digits_q[63:60];
	assign digits_shl = oct_q ? {digits_q[60:0], 3'b0} : {digits_q[59:0], 4'b0};
	assign bcd_next   = dabble4(bcd_q, bin_q[31:28]);
	assign pop        = (state_q == ST_IDLE) && !stat.empty;

	// Sequence one conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe    <= 1'b0;
			result    <= '0;
			digits_q  <= '0;
			bcd_q     <= '0;
			bin_q     <= '0;
			step_q    <= '0;
			cnt_q     <= '0;
			oct_q     <= 1'b0;
			neg_q     <= 1'b0;
			ptr_q     <= 1'b0;
			pre_idx_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!stat.empty) begin
						neg_q     <= head.neg;
						ptr_q     <= head.ptr;
						pre_idx_q <= 1'b0;
						oct_q     <= (head.base == itoa_fmt_pkg::BASE_OCT);
						case (head.base)
							itoa_fmt_pkg::BASE_OCT: begin
								digits_q <= {1'b0, head.mag[31:0], 31'b0};
								cnt_q    <= 5'd11;
								state_q  <= ST_SKIP;
							end
							itoa_fmt_pkg::BASE_HEX: begin
								if (head.ptr) begin
									digits_q <= head.mag << PAD;
									cnt_q    <= 5'(NIB);
								end else begin
									digits_q <= {head.mag[31:0], 32'b0};
									cnt_q    <= 5'd8;
								end
								state_q <= ST_SKIP;
							end
							default: begin
								bin_q   <= head.mag[31:0];
								bcd_q   <= '0;
								step_q  <= '0;
								state_q <= ST_DABBLE;
							end
						endcase
					end
				end
				ST_DABBLE: begin
					bcd_q  <= bcd_next;
					bin_q  <= {bin_q[27:0], 4'b0};
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						digits_q <= {bcd_next, 24'b0};
						cnt_q    <= 5'd10;
						state_q  <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zeros, keep at least one digit
					if (top == 4'd0 && cnt_q > 5'd1) begin
						digits_q <= digits_shl;
						cnt_q    <= cnt_q - 5'd1;
					end else if (neg_q || ptr_q) begin
						state_q <= ST_PRE;
					end else begin
						state_q <= ST_DIG;
					end
				end
				ST_PRE: begin
					strobe      <= 1'b1;
					result.last <= 1'b0;
					if (neg_q) begin
						result.char_code <= itoa_fmt_pkg::CHAR_MINUS;
						state_q          <= ST_DIG;
					end else if (!pre_idx_q) begin
						result.char_code <= itoa_fmt_pkg::CHAR_ZERO;
						pre_idx_q        <= 1'b1;
					end else begin
						result.char_code <= itoa_fmt_pkg::CHAR_X;
						state_q          <= ST_DIG;
					end
				end
				ST_DIG: begin
					strobe           <= 1'b1;
					result.char_code <= itoa_fmt_pkg::glyph(top);
					result.last      <= (cnt_q == 5'd1);
					digits_q         <= digits_shl;
					cnt_q            <= cnt_q - 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/integer_to_ascii_radix_formatter_core.sv -----
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_formatter_core
// Formats a value as ASCII decimal, octal or hex text, one character a cycle.
// ---------------------------------------------------------------------------
// Command channel: a command (mode, value) is taken at a rising edge with
// start high and busy low. Modes 5 to 7 are taken and dropped silently.
// Result channel: each character appears on result for one cycle with strobe
// high; result.last marks the final character. The receiver cannot stall.
// Front and back are parted by a two-entry job queue, so busy rises only when
// the front register and the queue are both full.
// From transfer to first character: the job passes the front register and
// the queue to reach the back, then decimal modes run the BCD conversion
// (4 bits per cycle), then leading zeros are suppressed, then prefix
// characters are emitted. The back takes one conversion at a time and pops
// no new job until the last character of the current one is out; the back's
// digit sequencer sets the throughput.
// Reset clears the queue, the front register and the sequencer at once;
// no character is emitted while reset is held.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_formatter_core #(
	parameter int POINTER_WIDTH = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  itoa_fmt_pkg::item_t   item,
	output logic                  strobe,
	output itoa_fmt_pkg::result_t result
);

	itoa_fmt_pkg::push_t      push;
	itoa_fmt_pkg::fifo_stat_t stat;
	itoa_fmt_pkg::job_t       head;
	logic                     pop;

	itoa_fmt_front #(
		.POINTER_WIDTH(POINTER_WIDTH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.stat  (stat),
		.push  (push)
	);

	itoa_fmt_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.stat  (stat)
	);

	itoa_fmt_back #(
		.POINTER_WIDTH(POINTER_WIDTH)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.stat  (stat),
		.pop   (pop),
		.strobe(strobe),
		.result(result)
	);

endmodule

`default_nettype wire

// ----- design/itoa_fmt_checker.sv -----
// ---------------------------------------------------------------------------
// itoa_fmt_checker
// Port-level checks on the formatter's character stream and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_formatter_core_assert.svh"

module itoa_fmt_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   busy,
	input wire                   strobe,
	input itoa_fmt_pkg::result_t result
);

	logic x_char;
	logic zero_char;
	logic minus_char;

	// Flag transfers of the fixed characters
	assign x_char     = strobe && (result.char_code == itoa_fmt_pkg::CHAR_X);
	assign zero_char  = strobe && (result.char_code == itoa_fmt_pkg::CHAR_ZERO);
	assign minus_char = strobe && (result.char_code == itoa_fmt_pkg::CHAR_MINUS);

	// An 'x' closes the pointer prefix: follows '0' and is never the last character
	`AST_IMPLY(a_x_after_zero, clk, arst_n, x_char, !result.last && $past(zero_char))

	// A digit transfer always follows the pointer prefix
	`AST_NEXT(a_x_then_digit, clk, arst_n, x_char, strobe)

	// A digit transfer always follows the minus sign
	`AST_NEXT(a_minus_then_digit, clk, arst_n, minus_char, strobe && !minus_char)

	// Hold both channels quiet during reset
	`AST_ALWAYS(a_reset_quiet, clk, arst_n || (!strobe && !busy))

endmodule

bind integer_to_ascii_radix_formatter_core itoa_fmt_checker u_checker (.*);

`default_nettype wire

// ----- bench/integer_to_ascii_radix_formatter_core_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_to_ascii_radix_formatter_core_test
// Self-checking bench for the ASCII radix formatter. Commands go in through
// the start/busy channel. Every transfer is run through a local text
// predictor, and each strobed character is compared with the oldest
// character still owed. Corner values come first, then the unused modes,
// then random traffic under three sender idle rates.
// ---------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_formatter_core_test;

	localparam int PTR_BITS = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	// Codes the block accepts but never answers
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	itoa_fmt_pkg::item_t   item;
	logic                  strobe;
	itoa_fmt_pkg::result_t result;

	// Characters owed by the block, oldest first
	itoa_fmt_pkg::result_t pending_chars[$];
	itoa_fmt_pkg::result_t want_char;

	int sender_idle_pct;
	int sent_cmds;
	int accepted_cmds;
	int chars_checked;
	int mismatch_count;
	int quiet_cycles;

	integer_to_ascii_radix_formatter_core #(
		.POINTER_WIDTH(PTR_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	// Toggle the clock every half period
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Build the text of one command and queue its characters
	function automatic void predict_text(input itoa_fmt_pkg::item_t cmd);
		string       glyphs = "0123456789abcdef";
		logic [63:0] mag;
		logic [63:0] radix;
		logic [63:0] ptr_mask;
		logic [7:0]  rev[$];
		logic [7:0]  text[$];
		ptr_mask = (PTR_BITS == 64) ? '1 : ((64'd1 << PTR_BITS) - 64'd1);
		mag = {32'b0, cmd.value[31:0]};
		radix = 64'd10;
		case (cmd.mode)
			itoa_fmt_pkg::MODE_SDEC: begin
				// Negative: sign first, then the unsigned magnitude
				if (mag[31]) begin
					text.push_back(itoa_fmt_pkg::CHAR_MINUS);
					mag = 64'h1_0000_0000 - mag;
				end
			end
			itoa_fmt_pkg::MODE_OCT: radix = 64'd8;
			itoa_fmt_pkg::MODE_UDEC: radix = 64'd10;
			itoa_fmt_pkg::MODE_HEX: radix = 64'd16;
			itoa_fmt_pkg::MODE_PTR: begin
				text.push_back(itoa_fmt_pkg::CHAR_ZERO);
				text.push_back(itoa_fmt_pkg::CHAR_X);
				mag = cmd.value & ptr_mask;
				radix = 64'd16;
			end
			default: return;
		endcase
		// Peel digits least significant first; zero still gives one digit
		do begin
			rev.push_back(glyphs[int'(mag % radix)]);
			mag = mag / radix;
		end while (mag != 0);
		while (rev.size() > 0) text.push_back(rev.pop_back());
		foreach (text[k]) begin
			pending_chars.push_back(itoa_fmt_pkg::result_t'{char_code: text[k],
				last: (k == text.size() - 1)});
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [8:0] exp_bits,
			input logic [8:0] got_bits);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s: expected char 0x%02h last %0d, got char 0x%02h last %0d",
				$realtime, what, exp_bits[8:1], exp_bits[0], got_bits[8:1],
				got_bits[0]);
		end
	endtask

	// Check each strobed character, then record any command transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (pending_chars.size() == 0) begin
					report_mismatch("unexpected character", 9'b0, result);
				end else begin
					want_char = pending_chars.pop_front();
					chars_checked++;
					if (result.char_code !== want_char.char_code ||
							result.last !== want_char.last) begin
						report_mismatch("character mismatch", want_char, result);
					end
				end
			end
			if (start && !busy) begin
				accepted_cmds++;
				predict_text(item);
			end
		end
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("integer_to_ascii_radix_formatter_core_test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one command, idling first at the current rate; hold until transfer
	task automatic send_cmd(input logic [2:0] mode, input logic [63:0] value);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= itoa_fmt_pkg::item_t'{mode: mode, value: value};
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_cmds++;
	endtask

	// Values biased toward digit-count boundaries and sign edges
	function automatic logic [63:0] pick_value();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return '0;
			1: return wide;
			2: return 64'($urandom_range(0, 20));
			3: return wide >> $urandom_range(0, 63);
			4: return {wide[63:32], 32'h8000_0000 | 32'($urandom_range(0, 3))};
			default: return {wide[63:32], 32'hffff_ffff - 32'($urandom_range(0, 3))};
		endcase
	endfunction

	task automatic test_corner_values();
		send_cmd(itoa_fmt_pkg::MODE_SDEC, 64'h0);
		send_cmd(itoa_fmt_pkg::MODE_SDEC, 64'h1);
		send_cmd(itoa_fmt_pkg::MODE_SDEC, 64'hffff_ffff_ffff_ffff);
		send_cmd(itoa_fmt_pkg::MODE_SDEC, 64'h1234_5678_8000_0000);
		send_cmd(itoa_fmt_pkg::MODE_SDEC, 64'hffff_ffff_7fff_ffff);
		send_cmd(itoa_fmt_pkg::MODE_OCT, 64'h0);
		send_cmd(itoa_fmt_pkg::MODE_OCT, 64'h0000_0000_ffff_ffff);
		send_cmd(itoa_fmt_pkg::MODE_OCT, 64'hffff_ffff_0000_0008);
		send_cmd(itoa_fmt_pkg::MODE_UDEC, 64'h0);
		send_cmd(itoa_fmt_pkg::MODE_UDEC, 64'h0000_0000_ffff_ffff);
		send_cmd(itoa_fmt_pkg::MODE_UDEC, 64'h5555_5555_3b9a_ca00);
		send_cmd(itoa_fmt_pkg::MODE_HEX, 64'h0);
		send_cmd(itoa_fmt_pkg::MODE_HEX, 64'h0000_0000_dead_beef);
		send_cmd(itoa_fmt_pkg::MODE_HEX, 64'haaaa_aaaa_0000_000f);
		send_cmd(itoa_fmt_pkg::MODE_PTR, 64'h0);
		send_cmd(itoa_fmt_pkg::MODE_PTR, 64'h1);
		send_cmd(itoa_fmt_pkg::MODE_PTR, 64'hffff_ffff_ffff_ffff);
		send_cmd(itoa_fmt_pkg::MODE_PTR, 64'hfedc_ba98_7654_3210);
	endtask

	task automatic test_unused_modes();
		for (int m = int'(MODE_UNUSED_LO); m <= int'(MODE_UNUSED_HI); m++) begin
			send_cmd(3'(m), {$urandom, $urandom});
		end
		// A real command right after the dropped ones
		send_cmd(itoa_fmt_pkg::MODE_HEX, 64'h0000_0000_0000_00a5);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int count);
		logic [2:0] mode;
		sender_idle_pct = idle_pct;
		repeat (count) begin
			if ($urandom_range(0, 99) < 6) begin
				mode = 3'($urandom_range(int'(MODE_UNUSED_LO), int'(MODE_UNUSED_HI)));
			end else begin
				mode = 3'($urandom_range(int'(itoa_fmt_pkg::MODE_SDEC),
					int'(itoa_fmt_pkg::MODE_PTR)));
			end
			send_cmd(mode, pick_value());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start = 1'b0;
		item = '0;
		sender_idle_pct = 13;
		sent_cmds = 0;
		accepted_cmds = 0;
		chars_checked = 0;
		mismatch_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_unused_modes();
		test_random_traffic(13, 46);
		test_random_traffic(48, 46);
		test_random_traffic(0, 46);
		start <= 1'b0;

		// Drain owed characters, then watch for strays
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d taken) over all five modes and the unused codes,",
			sent_cmds, accepted_cmds);
		$display("checked %0d characters under three sender idle rates.", chars_checked);
		if (mismatch_count == 0 && pending_chars.size() == 0) begin
			$display("integer_to_ascii_radix_formatter_core_test passed");
		end else begin
			$display("integer_to_ascii_radix_formatter_core_test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
